/* sv/rme_pkg.sv */
// Package for the RSA modular exponentiation block.
// Holds widths, register indexes, reset values, FSM state type, the multiplier interface structs
// and the width conversion functions. No dependencies.
package rme_pkg;

    // Working width of the modular arithmetic (8 to 64)
    localparam int MOD_W     = 32;
    // Field and register widths
    localparam int DATA_W    = 32;
    localparam int EXP_W     = 32;
    localparam int MCNT_W    = $clog2(MOD_W + 1);
    localparam int ECNT_W    = $clog2(EXP_W + 1);
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b1;

    // Reset values of the configuration registers
    localparam logic [DATA_W-1:0] EXPONENT_RST = DATA_W'(1);
    localparam logic [DATA_W-1:0] MODULUS_RST  = DATA_W'(2);

    typedef logic [MOD_W-1:0] mod_word_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQR,
        ST_MUL,
        ST_OUT
    } rme_state_t;

    // Multiplier request: product a * b mod m, a < m
    typedef struct packed {
        logic      start;
        mod_word_t a;
        mod_word_t b;
        mod_word_t m;
    } mm_req_t;

    // Multiplier status
    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

    // 32-bit field to working width (zero-extend or truncate)
    function automatic mod_word_t to_mod(input logic [DATA_W-1:0] x);
        mod_word_t r;
        r = '0;
        for (int i = 0; i < MOD_W; i++) begin
            if (i < DATA_W) r[i] = x[i];
        end
        return r;
    endfunction

    // Working width to 32-bit field
    function automatic logic [DATA_W-1:0] from_mod(input mod_word_t x);
        logic [DATA_W-1:0] r;
        r = '0;
        for (int i = 0; i < DATA_W; i++) begin
            if (i < MOD_W) r[i] = x[i];
        end
        return r;
    endfunction

endpackage

/* sv/rme_mulmod.sv */
// Bit-serial modular multiplier: a * b mod m, one bit of b per cycle, MSB first.
// Depends on rme_pkg.
module rme_mulmod (
    input  logic              aclk,
    input  logic              aresetn,
    input  rme_pkg::mm_req_t  req,
    output rme_pkg::mm_stat_t stat,
    output rme_pkg::mod_word_t result
);

    rme_pkg::mod_word_t              a_reg, m_reg, b_sh_reg, acc_reg;
    rme_pkg::mod_word_t              acc_next;
    logic [rme_pkg::MCNT_W-1:0]      cnt_reg;
    logic                            done_reg;
    logic [rme_pkg::MOD_W+1:0]       t_sum, m1_ext, m2_ext;

    // acc = 2*acc + bit*a, then fold back below m (sum stays under 3m)
    always_comb begin
        t_sum  = {1'b0, acc_reg, 1'b0}
               + (b_sh_reg[rme_pkg::MOD_W-1] ? {2'b00, a_reg} : '0);
        m1_ext = {2'b00, m_reg};
        m2_ext = {1'b0, m_reg, 1'b0};
        priority if (t_sum >= m2_ext) begin
            acc_next = rme_pkg::MOD_W'(t_sum - m2_ext);
        end else if (t_sum >= m1_ext) begin
            acc_next = rme_pkg::MOD_W'(t_sum - m1_ext);
        end else begin
            acc_next = rme_pkg::MOD_W'(t_sum);
        end
    end

    // bit counter and done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (req.start && cnt_reg == '0) begin
            cnt_reg  <= rme_pkg::MCNT_W'(rme_pkg::MOD_W);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == rme_pkg::MCNT_W'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    // operand and accumulator datapath
    always_ff @(posedge aclk) begin
        if (req.start && cnt_reg == '0) begin
            a_reg    <= req.a;
            m_reg    <= req.m;
            b_sh_reg <= req.b;
            acc_reg  <= '0;
        end else if (cnt_reg != '0) begin
            acc_reg  <= acc_next;
            b_sh_reg <= {b_sh_reg[rme_pkg::MOD_W-2:0], 1'b0};
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign result    = acc_reg;

endmodule

/* sv/rsa_modular_exponentiation.sv */
// Top level: RSA modular exponentiation by left-to-right square-and-multiply.
// Depends on rme_pkg and rme_mulmod (shared bit-serial modular multiplier).
//
// Channel  | Dir | Ports                              | Content
// ---------+-----+------------------------------------+------------------------------
// input    | in  | s_tvalid s_tready s_tdata s_tlast  | message_value, last_in
// result   | out | m_tvalid m_tready m_tdata m_tlast  | result_value, last_out
// config   | in  | cfg_wr_en cfg_addr cfg_wdata       | 0: exponent, 1: modulus
//
// Each beat runs from accept to the next accept through the reduction, one squaring per
// exponent bit and one multiply per set bit, each of MOD_W bit steps and a done pulse in
// the single shared bit-serial multiplier.
// A modulus below 2 returns 0 without using the multiplier.
// Reset is synchronous, active low; it sets exponent to 1 and modulus to 2.
// A finished result waits in the output register; the next beat is taken meanwhile.
module rsa_modular_exponentiation (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rme_pkg::DATA_W-1:0]      s_tdata,   // [31:0] message_value
    input  logic                            s_tlast,   // last_in
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rme_pkg::DATA_W-1:0]      m_tdata,   // [31:0] result_value
    output logic                            m_tlast,   // last_out
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [rme_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [rme_pkg::DATA_W-1:0]      cfg_wdata
);

    rme_pkg::rme_state_t             state_reg, state_next;
    logic [rme_pkg::DATA_W-1:0]      exponent_reg, modulus_reg;
    logic [rme_pkg::EXP_W-1:0]       exp_sh_reg, exp_sh_next;
    logic [rme_pkg::ECNT_W-1:0]      ecnt_reg, ecnt_next;
    rme_pkg::mod_word_t              m_reg, m_next;
    rme_pkg::mod_word_t              base_reg, base_next;
    rme_pkg::mod_word_t              acc_reg, acc_next;
    logic                            last_reg, last_next;
    logic                            m_tvalid_reg;
    logic [rme_pkg::DATA_W-1:0]      m_tdata_reg;
    logic                            m_tlast_reg;
    logic                            out_load;
    rme_pkg::mm_req_t                mm_req;
    rme_pkg::mm_stat_t               mm_stat;
    rme_pkg::mod_word_t              mm_res;
    rme_pkg::mod_word_t              mod_in;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exponent_reg <= rme_pkg::EXPONENT_RST;
            modulus_reg  <= rme_pkg::MODULUS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                rme_pkg::REG_EXPONENT: exponent_reg <= cfg_wdata;
                rme_pkg::REG_MODULUS:  modulus_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    rme_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req),
        .stat    (mm_stat),
        .result  (mm_res)
    );

    assign mod_in   = rme_pkg::to_mod(modulus_reg);
    assign s_tready = (state_reg == rme_pkg::ST_IDLE);
    assign out_load = (state_reg == rme_pkg::ST_OUT) && (!m_tvalid_reg || m_tready);

    // sequencer: reduce, then square (and multiply) per exponent bit; a modulus below 2 goes straight to output
    always_comb begin
        state_next  = state_reg;
        exp_sh_next = exp_sh_reg;
        ecnt_next   = ecnt_reg;
        m_next      = m_reg;
        base_next   = base_reg;
        acc_next    = acc_reg;
        last_next   = last_reg;
        mm_req      = '{start: 1'b0, a: mm_res, b: mm_res, m: m_reg};
        unique case (state_reg)
            rme_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    m_next      = mod_in;
                    exp_sh_next = exponent_reg;
                    last_next   = s_tlast;
                    if (mod_in < rme_pkg::MOD_W'(2)) begin
                        acc_next   = '0;
                        state_next = rme_pkg::ST_OUT;
                    end else begin
                        // value mod m as 1 * value mod m
                        mm_req     = '{start: 1'b1, a: rme_pkg::MOD_W'(1),
                                       b: rme_pkg::to_mod(s_tdata), m: mod_in};
                        state_next = rme_pkg::ST_REDUCE;
                    end
                end
            end
            rme_pkg::ST_REDUCE: begin
                if (mm_stat.done) begin
                    base_next  = mm_res;
                    ecnt_next  = rme_pkg::ECNT_W'(rme_pkg::EXP_W);
                    mm_req     = '{start: 1'b1, a: rme_pkg::MOD_W'(1),
                                   b: rme_pkg::MOD_W'(1), m: m_reg};
                    state_next = rme_pkg::ST_SQR;
                end
            end
            rme_pkg::ST_SQR: begin
                if (mm_stat.done) begin
                    acc_next = mm_res;
                    if (exp_sh_reg[rme_pkg::EXP_W-1]) begin
                        mm_req     = '{start: 1'b1, a: mm_res, b: base_reg, m: m_reg};
                        state_next = rme_pkg::ST_MUL;
                    end else begin
                        exp_sh_next = {exp_sh_reg[rme_pkg::EXP_W-2:0], 1'b0};
                        ecnt_next   = ecnt_reg - 1'b1;
                        if (ecnt_reg == rme_pkg::ECNT_W'(1)) begin
                            state_next = rme_pkg::ST_OUT;
                        end else begin
                            mm_req.start = 1'b1;
                        end
                    end
                end
            end
            rme_pkg::ST_MUL: begin
                if (mm_stat.done) begin
                    acc_next    = mm_res;
                    exp_sh_next = {exp_sh_reg[rme_pkg::EXP_W-2:0], 1'b0};
                    ecnt_next   = ecnt_reg - 1'b1;
                    if (ecnt_reg == rme_pkg::ECNT_W'(1)) begin
                        state_next = rme_pkg::ST_OUT;
                    end else begin
                        mm_req.start = 1'b1;
                        state_next   = rme_pkg::ST_SQR;
                    end
                end
            end
            rme_pkg::ST_OUT: begin
                if (out_load) state_next = rme_pkg::ST_IDLE;
            end
            default: state_next = rme_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rme_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        exp_sh_reg <= exp_sh_next;
        ecnt_reg   <= ecnt_next;
        m_reg      <= m_next;
        base_reg   <= base_next;
        acc_reg    <= acc_next;
        last_reg   <= last_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= rme_pkg::from_mod(acc_reg);
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // a beat is only taken while the multiplier is free
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !mm_stat.busy)
        else $error("beat accepted while multiplier busy");

    // multiplier finishes only while the sequencer waits on it
    a_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_stat.done |-> (state_reg == rme_pkg::ST_REDUCE || state_reg == rme_pkg::ST_SQR
                          || state_reg == rme_pkg::ST_MUL))
        else $error("multiplier done outside a wait state");

    // delivered value is reduced below the modulus, unless the modulus is below 2
    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (acc_reg < m_reg || m_reg < rme_pkg::MOD_W'(2)))
        else $error("result not reduced");

    // multiplier starts only when idle
    a_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_req.start |-> !mm_stat.busy)
        else $error("multiplier started while busy");

endmodule
